// ===== rtl/ffea_pkg.sv =====
// Shared types and constants for the first-fit extent allocator.
// No dependencies.
`default_nettype none
package ffea_pkg;
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;
   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_NO_FIT = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/ffea_table.sv =====
// Extent table: two synchronous memories (start, length), one read and one write port each.
// Depends on ffea_pkg.
`default_nettype none
module ffea_table import ffea_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 32,
   localparam int IW   = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic [IW-1:0] rd_idx,
   output logic      [AW-1:0] rd_start,
   output logic      [AW-1:0] rd_length,
   input  wire logic          wr_en,
   input  wire logic [IW-1:0] wr_idx,
   input  wire logic [AW-1:0] wr_start,
   input  wire logic [AW-1:0] wr_length
);
   logic [AW-1:0] start_mem [DEPTH];
   logic [AW-1:0] length_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_mem[wr_idx]  <= wr_start;
         length_mem[wr_idx] <= wr_length;
      end
      rd_start  <= start_mem[rd_idx];
      rd_length <= length_mem[rd_idx];
   end
endmodule
`default_nettype wire

// ===== rtl/first_fit_extent_allocator.sv =====
// Top level: sequencer that scans, shifts and merges the extent table.
// Depends on ffea_pkg and ffea_table.
//
//  channel | ports                                          | dir
//  req     | req_valid/ready, command, offset, length       | in
//  rsp     | rsp_valid/ready, granted_offset, status         | out
//  csr     | csr_valid/ready, csr_heap_size                  | in
//
// One word is processed at a time. The scan reads each entry and then waits for
// the registered read data; moving an entry takes a read and then a write.
// An allocate stops at the first fit; an exact fit then closes the gap after its result.
// A free scans, opens a hole, runs a merge pass and makes up to two removals.
// Reset and a heap_size write rebuild entry 0.
// The result sits in an output register; the next word is taken once it is sent.
`default_nettype none
module first_fit_extent_allocator import ffea_pkg::*; #(
   parameter int MAX_EXTENTS = 64,
   parameter int ADDR_BITS   = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_command,
   input  wire logic [31:0] req_request_offset,
   input  wire logic [31:0] req_request_length,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_granted_offset,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_heap_size
);
   localparam int IW = $clog2(MAX_EXTENTS);
   localparam int CW = $clog2(MAX_EXTENTS + 1);
   localparam int AW = ADDR_BITS;
   localparam int WW = (AW > 32) ? AW : 32;
   localparam logic [AW-1:0] MAXA = {AW{1'b1}};
   localparam logic [AW-1:0] HEAP_RST = (AW > 16) ? AW'(64'd65536) : MAXA;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_RD    = 8'b00000010,  // issue read at idx
      S_CHK   = 8'b00000100,  // scan data back
      S_SHRD  = 8'b00001000,  // shift: read source entry
      S_SHWR  = 8'b00010000,  // shift: write moved entry
      S_MRD   = 8'b00100000,  // merge: read entry idx+1
      S_MCHK  = 8'b01000000,
      S_RESP  = 8'b10000000
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          cmd_ff, cmd_in;
   logic          up_ff, up_in;        // shift direction: up = open a hole
   logic [CW-1:0] stop_ff, stop_in;    // shift bound
   logic [AW-1:0] off_ff, off_in, len_ff, len_in;
   logic [AW-1:0] cs_ff, cs_in, cl_ff, cl_in;  // current (merge left) entry
   logic [31:0]   gr_ff, gr_in;
   logic [1:0]    st_ff, st_in;
   logic          rv_ff, rv_in;

   logic [IW-1:0] rd_idx, wr_idx;
   logic [AW-1:0] rd_start, rd_length, wr_start, wr_length;
   logic          wr_en;
   logic [AW-1:0] hs;
   logic [AW:0]   endsum;

   ffea_table #(.DEPTH(MAX_EXTENTS), .AW(AW)) u_table (
      .clock, .rd_idx, .rd_start, .rd_length,
      .wr_en, .wr_idx, .wr_start, .wr_length
   );

   always_comb begin
      logic [WW-1:0] h;
      h = WW'(csr_heap_size);
      hs = (h > WW'(MAXA)) ? MAXA : AW'(h);
   end

   // a pending heap_size write wins over a request word
   assign req_ready = (state_ff == S_IDLE) && !rv_ff && !csr_valid;
   assign csr_ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_granted_offset = gr_ff;
   assign rsp_status = st_ff;
   assign endsum = {1'b0, cs_ff} + {1'b0, cl_ff};

   always_comb begin
      logic [WW-1:0] o, l;
      logic [AW-1:0] room;
      state_in = state_ff; count_in = count_ff; idx_in = idx_ff; cmd_in = cmd_ff;
      up_in = up_ff; stop_in = stop_ff; off_in = off_ff; len_in = len_ff;
      cs_in = cs_ff; cl_in = cl_ff; gr_in = gr_ff; st_in = st_ff; rv_in = rv_ff;
      rd_idx = idx_ff[IW-1:0];
      wr_en = 1'b0; wr_idx = idx_ff[IW-1:0]; wr_start = cs_ff; wr_length = cl_ff;
      o = '0; l = '0; room = '0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (csr_valid && csr_ready) begin
               wr_en = 1'b1; wr_idx = '0; wr_start = '0; wr_length = hs;
               count_in = CW'(1);
            end else if (req_valid && req_ready) begin
               cmd_in = req_command; idx_in = '0; gr_in = '0; st_in = ST_DONE;
               o = WW'(req_request_offset); l = WW'(req_request_length);
               off_in = AW'(o); room = MAXA - AW'(o);
               if (req_command == CMD_ALLOC) begin
                  len_in = (l > WW'(MAXA)) ? MAXA : AW'(l);
                  if (l > WW'(MAXA) || count_ff == '0) begin
                     st_in = ST_NO_FIT; rv_in = 1'b1;
                  end else state_in = S_RD;
               end else begin
                  len_in = (l > WW'(room)) ? room : AW'(l);
                  if (l == '0 || room == '0) rv_in = 1'b1;
                  else if (count_ff >= CW'(MAX_EXTENTS)) begin
                     st_in = ST_FULL; rv_in = 1'b1;
                  end else if (count_ff == '0) begin
                     idx_in = '0; stop_in = '0; up_in = 1'b1; state_in = S_SHRD;
                  end else state_in = S_RD;
               end
            end
         end
         S_RD: state_in = S_CHK;
         S_CHK: begin
            if (cmd_ff == CMD_ALLOC) begin
               if (rd_length >= len_ff) begin
                  gr_in = 32'(rd_start);
                  rv_in = 1'b1;
                  if (rd_length == len_ff) begin
                     up_in = 1'b0; stop_in = count_ff - CW'(1);
                     count_in = count_ff - CW'(1); state_in = S_SHRD;
                  end else begin
                     wr_en = 1'b1; wr_start = rd_start + len_ff;
                     wr_length = rd_length - len_ff; state_in = S_IDLE;
                  end
               end else if (idx_ff + CW'(1) == count_ff) begin
                  st_in = ST_NO_FIT; rv_in = 1'b1; state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + CW'(1); state_in = S_RD;
               end
            end else begin
               if (rd_start >= off_ff || idx_ff + CW'(1) == count_ff) begin
                  // insert position found; shift tail up from the top
                  stop_in = (rd_start >= off_ff) ? idx_ff : count_ff;
                  idx_in = count_ff; up_in = 1'b1; state_in = S_SHRD;
               end else begin
                  idx_in = idx_ff + CW'(1); state_in = S_RD;
               end
            end
         end
         S_SHRD: begin
            if (up_ff) begin
               if (idx_ff == stop_ff) begin
                  wr_en = 1'b1; wr_start = off_ff; wr_length = len_ff;
                  count_in = count_ff + CW'(1);
                  idx_in = '0; cs_in = '0; cl_in = '0;
                  rd_idx = '0; state_in = S_MRD;
                  up_in = 1'b0;
               end else begin
                  rd_idx = IW'(idx_ff - CW'(1)); state_in = S_SHWR;
               end
            end else begin
               if (idx_ff >= stop_ff) state_in = S_IDLE;
               else begin
                  rd_idx = IW'(idx_ff + CW'(1)); state_in = S_SHWR;
               end
            end
         end
         S_SHWR: begin
            wr_en = 1'b1; wr_start = rd_start; wr_length = rd_length;
            idx_in = up_ff ? idx_ff - CW'(1) : idx_ff + CW'(1);
            state_in = S_SHRD;
         end
         S_MRD: begin
            // first visit loads entry 0 as the left entry
            if (cl_ff == '0 && cs_ff == '0 && idx_ff == '0 && !up_ff) begin
               up_in = 1'b1; state_in = S_MCHK;
            end else if (idx_ff + CW'(1) >= count_ff) begin
               rv_in = 1'b1; state_in = S_IDLE;
            end else begin
               rd_idx = IW'(idx_ff + CW'(1)); state_in = S_MCHK;
            end
         end
         S_MCHK: begin
            if (up_ff) begin
               cs_in = rd_start; cl_in = rd_length; up_in = 1'b0;
               if (count_ff <= CW'(1)) begin
                  rv_in = 1'b1; state_in = S_IDLE;
               end else begin
                  rd_idx = IW'(CW'(1)); state_in = S_RESP;
               end
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            // rd_* holds entry idx+1, cs/cl hold entry idx
            if (endsum == {1'b0, rd_start}) begin
               cl_in = cl_ff + rd_length;
               wr_en = 1'b1; wr_start = cs_ff; wr_length = cl_ff + rd_length;
               // remove entry idx+1, then resume merge at idx
               up_in = 1'b0; stop_in = count_ff - CW'(1);
               count_in = count_ff - CW'(1);
               idx_in = idx_ff + CW'(1);
               state_in = S_SHRD;
               cmd_in = CMD_FREE;
               gr_in = gr_ff;
               off_in = AW'(idx_ff);  // remember merge point
            end else begin
               cs_in = rd_start; cl_in = rd_length; idx_in = idx_ff + CW'(1);
               if (idx_ff + CW'(2) >= count_ff) begin
                  rv_in = 1'b1; state_in = S_IDLE;
               end else begin
                  rd_idx = IW'(idx_ff + CW'(2)); state_in = S_RESP;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      // a removal during merge returns to the merge scan instead of idle
      if (state_ff == S_SHRD && !up_ff && idx_ff >= stop_ff && cmd_ff == CMD_FREE) begin
         idx_in = CW'(off_ff);
         if (CW'(off_ff) + CW'(1) >= count_ff) begin
            rv_in = 1'b1; state_in = S_IDLE;
         end else begin
            rd_idx = IW'(CW'(off_ff) + CW'(1)); state_in = S_RESP;
         end
      end
      // entry 0 is rebuilt with the reset heap while reset is held
      if (reset) begin
         wr_en = 1'b1; wr_idx = '0; wr_start = '0; wr_length = HEAP_RST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= CW'(1);
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
      idx_ff <= idx_in; cmd_ff <= cmd_in; up_ff <= up_in; stop_ff <= stop_in;
      off_ff <= off_in; len_ff <= len_in; cs_ff <= cs_in; cl_ff <= cl_in;
      gr_ff <= gr_in; st_ff <= st_in;
   end

   // marks the first cycle after reset
   logic init_ff;
   always_ff @(posedge clock) init_ff <= reset;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_EXTENTS)) else $error("extent count overflow");
   assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_ready |=> rv_ff) else $error("result lost");
   assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> rsp_status != 2'd3) else $error("bad status code");
   assert property (@(posedge clock) disable iff (reset)
      init_ff |-> state_ff == S_IDLE) else $error("busy after reset");
endmodule
`default_nettype wire
